/* rtl/prs2_pkg.sv */
// Shared constants and types for the 2x2 rank-order downsampler.
// Used by prs2_rank4, pyramid_rank_select_2x2_unit and its bench; depends on nothing.
package prs2_pkg;

  // Pixel and configuration field widths
  localparam int PIX_W  = 8;
  localparam int DIM_W  = 12;
  localparam int LIM_W  = 11;
  localparam int RANK_W = 3;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 3;

  // Default size limits of the line store and row counter
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_RANK       = 3'd4;

  // Register reset values
  localparam logic [DIM_W-1:0]  RST_IN_WIDTH   = 12'd2048;
  localparam logic [DIM_W-1:0]  RST_IN_HEIGHT  = 12'd2048;
  localparam logic [LIM_W-1:0]  RST_OUT_WIDTH  = 11'd1024;
  localparam logic [LIM_W-1:0]  RST_OUT_HEIGHT = 11'd1024;
  localparam logic [RANK_W-1:0] RST_RANK       = 3'd1;

  // Rank codes
  localparam logic [RANK_W-1:0] RANK_ZERO = 3'd0;
  localparam logic [RANK_W-1:0] RANK_MIN  = 3'd1;
  localparam logic [RANK_W-1:0] RANK_LO   = 3'd2;
  localparam logic [RANK_W-1:0] RANK_HI   = 3'd3;

  typedef logic [PIX_W-1:0] pixel_t;

endpackage

/* rtl/prs2_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module prs2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/prs2_rank4.sv */
// Four-input sorting network with rank selection.
// Depends on prs2_pkg for pixel type and rank codes.
module prs2_rank4 (
  input  prs2_pkg::pixel_t              a,
  input  prs2_pkg::pixel_t              b,
  input  prs2_pkg::pixel_t              c,
  input  prs2_pkg::pixel_t              d,
  input  logic [prs2_pkg::RANK_W-1:0]   rank,
  output prs2_pkg::pixel_t              y
);

  prs2_pkg::pixel_t lo_ab, hi_ab, lo_cd, hi_cd;
  prs2_pkg::pixel_t s0, s1, s2, s3, m_lo, m_hi;

  always_comb begin
    // sort pairs, then merge extremes, then order the middle pair
    lo_ab = (a < b) ? a : b;
    hi_ab = (a < b) ? b : a;
    lo_cd = (c < d) ? c : d;
    hi_cd = (c < d) ? d : c;
    s0    = (lo_ab < lo_cd) ? lo_ab : lo_cd;
    m_lo  = (lo_ab < lo_cd) ? lo_cd : lo_ab;
    s3    = (hi_ab < hi_cd) ? hi_cd : hi_ab;
    m_hi  = (hi_ab < hi_cd) ? hi_ab : hi_cd;
    s1    = (m_lo < m_hi) ? m_lo : m_hi;
    s2    = (m_lo < m_hi) ? m_hi : m_lo;

    case (rank)
      prs2_pkg::RANK_ZERO: y = s0;
      prs2_pkg::RANK_MIN:  y = s0;
      prs2_pkg::RANK_LO:   y = s1;
      prs2_pkg::RANK_HI:   y = s2;
      default:             y = s3;
    endcase
  end

endmodule

/* rtl/pyramid_rank_select_2x2_unit.sv */
// 2x2 rank-order downsampler: top level with config registers and line store.
// Depends on prs2_pkg, prs2_ram and prs2_rank4.
// Path: the window's last pixel is registered in the window stage, then in the output register.
// Throughput: one pixel per cycle unless out_ready stalls; one line-store read per window.
// Reset: synchronous; clears positions, handshake state and loads register defaults.
// The line store is not cleared; it needs no clearing pass and is ready right after reset.
module pyramid_rank_select_2x2_unit #(
  parameter int MAX_WIDTH  = prs2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = prs2_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [prs2_pkg::IDX_W-1:0]    cfg_index,
  input  logic [prs2_pkg::CFG_W-1:0]    cfg_data,
  // input pixel stream
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [prs2_pkg::PIX_W-1:0]    pixel_in,
  // output pixel stream
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prs2_pkg::PIX_W-1:0]    pixel_out,
  output logic                          row_end,
  output logic                          frame_end
);

  // Column and row counter widths; comparison widths cover both counters and registers
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int XW     = (CW + 1 > prs2_pkg::DIM_W) ? CW + 1 : prs2_pkg::DIM_W;
  localparam int YW     = (RW + 1 > prs2_pkg::DIM_W) ? RW + 1 : prs2_pkg::DIM_W;
  // Line store split into even-column and odd-column banks, one entry per window column
  localparam int HALF_W = MAX_WIDTH / 2;
  localparam int HALF_H = MAX_HEIGHT / 2;
  localparam int AW     = (HALF_W > 1) ? $clog2(HALF_W) : 1;

  // Configuration registers
  logic [prs2_pkg::DIM_W-1:0]  in_width, in_height;
  logic [prs2_pkg::LIM_W-1:0]  out_width, out_height;
  logic [prs2_pkg::RANK_W-1:0] rank_select;

  // Raster position and bottom-left pixel of the current window
  logic [CW-1:0]          col, col_next;
  logic [RW-1:0]          row, row_next;
  prs2_pkg::pixel_t       left_bottom;

  // Window stage: holds the bottom-right pixel while the line store read lands
  logic                   s1_valid;
  prs2_pkg::pixel_t       s1_pixel, s1_left;
  logic                   s1_row_end, s1_frame_end;

  // Geometry decode
  logic [XW-1:0] w_lim, xs_in, xsize, col_x, col_half;
  logic [YW-1:0] h_lim, ys_in, ysize, row_x, row_half;
  logic          col_in, row_in, in_grid, col_last, row_last, col_wrap, row_wrap;

  logic          accept, s1_adv, make_result;
  logic          wr_even, wr_odd;
  logic [AW-1:0] store_addr;
  prs2_pkg::pixel_t top_left, top_right, ranked;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      in_width    <= prs2_pkg::RST_IN_WIDTH;
      in_height   <= prs2_pkg::RST_IN_HEIGHT;
      out_width   <= prs2_pkg::RST_OUT_WIDTH;
      out_height  <= prs2_pkg::RST_OUT_HEIGHT;
      rank_select <= prs2_pkg::RST_RANK;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        prs2_pkg::REG_IN_WIDTH:   in_width    <= cfg_data[prs2_pkg::DIM_W-1:0];
        prs2_pkg::REG_IN_HEIGHT:  in_height   <= cfg_data[prs2_pkg::DIM_W-1:0];
        prs2_pkg::REG_OUT_WIDTH:  out_width   <= cfg_data[prs2_pkg::LIM_W-1:0];
        prs2_pkg::REG_OUT_HEIGHT: out_height  <= cfg_data[prs2_pkg::LIM_W-1:0];
        prs2_pkg::REG_RANK:       rank_select <= cfg_data[prs2_pkg::RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // Horizontal geometry: wrap limit saturates to [1, MAX_WIDTH]; output columns
  // are the lesser of half the input width and the output limit.
  always_comb begin
    if (XW'(in_width) == '0) begin
      w_lim = XW'(1);
    end else if (XW'(in_width) > XW'(MAX_WIDTH)) begin
      w_lim = XW'(MAX_WIDTH);
    end else begin
      w_lim = XW'(in_width);
    end
    xs_in    = (XW'(in_width) > XW'(MAX_WIDTH)) ? XW'(HALF_W) : (XW'(in_width) >> 1);
    xsize    = (XW'(out_width) < xs_in) ? XW'(out_width) : xs_in;
    col_x    = XW'(col);
    col_half = col_x >> 1;
    col_in   = col_half < xsize;
    col_last = col_half == (xsize - XW'(1));
    col_wrap = (col_x + XW'(1)) >= w_lim;
  end

  // Vertical geometry, same rules as horizontal
  always_comb begin
    if (YW'(in_height) == '0) begin
      h_lim = YW'(1);
    end else if (YW'(in_height) > YW'(MAX_HEIGHT)) begin
      h_lim = YW'(MAX_HEIGHT);
    end else begin
      h_lim = YW'(in_height);
    end
    ys_in    = (YW'(in_height) > YW'(MAX_HEIGHT)) ? YW'(HALF_H) : (YW'(in_height) >> 1);
    ysize    = (YW'(out_height) < ys_in) ? YW'(out_height) : ys_in;
    row_x    = YW'(row);
    row_half = row_x >> 1;
    row_in   = row_half < ysize;
    row_last = row_half == (ysize - YW'(1));
    row_wrap = (row_x + YW'(1)) >= h_lim;
  end

  // Handshake: the window stage drains into the output register when that is
  // empty or being taken; a new pixel enters whenever the window stage can move.
  assign in_grid     = col_in && row_in;
  assign make_result = in_grid && row[0] && col[0];
  assign s1_adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready    = !s1_valid || s1_adv;
  assign accept      = in_valid && in_ready;

  // Raster position advance with wrap at row and frame end
  always_comb begin
    col_next = col;
    row_next = row;
    if (accept) begin
      if (col_wrap) begin
        col_next = '0;
        row_next = row_wrap ? '0 : row + RW'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      left_bottom <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      // hold the bottom-left pixel of the window until its partner arrives
      if (accept && in_grid && row[0] && !col[0]) begin
        left_bottom <= pixel_in;
      end
    end
  end

  // Line store: even rows write, odd-row odd columns read both top pixels at once
  assign store_addr = AW'(col >> 1);
  assign wr_even    = accept && in_grid && !row[0] && !col[0];
  assign wr_odd     = accept && in_grid && !row[0] && col[0];

  prs2_ram #(
    .WIDTH (prs2_pkg::PIX_W),
    .DEPTH (HALF_W)
  ) u_store_even (
    .clk     (clk),
    .wr_en   (wr_even),
    .wr_addr (store_addr),
    .wr_data (pixel_in),
    .rd_en   (accept && make_result),
    .rd_addr (store_addr),
    .rd_data (top_left)
  );

  prs2_ram #(
    .WIDTH (prs2_pkg::PIX_W),
    .DEPTH (HALF_W)
  ) u_store_odd (
    .clk     (clk),
    .wr_en   (wr_odd),
    .wr_addr (store_addr),
    .wr_data (pixel_in),
    .rd_en   (accept && make_result),
    .rd_addr (store_addr),
    .rd_data (top_right)
  );

  // Window stage: capture the bottom pair and end markers as the read issues.
  // The read data holds while the stage stalls since no new read issues then.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && make_result) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && make_result) begin
      s1_pixel     <= pixel_in;
      s1_left      <= left_bottom;
      s1_row_end   <= col_last;
      s1_frame_end <= col_last && row_last;
    end
  end

  prs2_rank4 u_rank (
    .a    (top_left),
    .b    (top_right),
    .c    (s1_left),
    .d    (s1_pixel),
    .rank (rank_select),
    .y    (ranked)
  );

  // Output register: load on window stage advance, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pixel_out <= ranked;
      row_end   <= s1_row_end;
      frame_end <= s1_frame_end;
    end
  end

endmodule

/* verif/tb_pyramid_rank_select_2x2_unit.sv */
// Self-checking bench for the 2x2 rank-order downsampler, directed rows then random frames.
// Needs prs2_pkg and the pyramid_rank_select_2x2_unit RTL; reads no files.
// Each window's expected value comes from a local predictor or a hand-written row and is compared on out transfer.
`timescale 1ns / 1ps

module tb_pyramid_rank_select_2x2_unit;
  import prs2_pkg::*;

  localparam int MAX_W           = DEF_MAX_WIDTH;
  localparam int MAX_H           = DEF_MAX_HEIGHT;
  localparam int PIPE_DEPTH      = 4;        // idle wait in settle() once no window is owed
  localparam int RAND_ITEMS      = 900;
  localparam int CALM_AFTER      = 760;      // no idling on either side past this many pixels
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 1000000;

  // Rank codes the package leaves out
  localparam logic [RANK_W-1:0] RANK_MAX     = 3'd4;
  localparam logic [RANK_W-1:0] RANK_ALL_SET = 3'd7;

  typedef struct packed {
    pixel_t pix;
    logic   row_end;
    logic   frame_end;
  } window_out_t;

  typedef enum logic [1:0] {ROW_REG, ROW_PIX, ROW_FILL} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       val;     // register value, pixel, or fill count
    bit                typed;   // want holds a hand-written result
    window_out_t       want;
  } stim_row_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  pixel_t            pixel_in  = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pixel_t            pixel_out;
  logic              row_end;
  logic              frame_end;

  // Predictor state: registers, line buffer and raster position
  logic [DIM_W-1:0]  cfg_in_w  = RST_IN_WIDTH;
  logic [DIM_W-1:0]  cfg_in_h  = RST_IN_HEIGHT;
  logic [LIM_W-1:0]  cfg_out_w = RST_OUT_WIDTH;
  logic [LIM_W-1:0]  cfg_out_h = RST_OUT_HEIGHT;
  logic [RANK_W-1:0] cfg_rank  = RST_RANK;
  pixel_t            line_buf [0:MAX_W-1];
  int unsigned       col_pos   = 0;
  int unsigned       row_pos   = 0;
  pixel_t            left_px   = '0;

  window_out_t       ranked_q [$];   // windows still owed by the block
  stim_row_t         dir_rows [$];

  int   errors       = 0;
  int   pixels_sent  = 0;
  int   windows_seen = 0;
  int   reg_writes   = 0;
  int   phases       = 0;
  int   gap_rate     = 0;      // 0 = sender never idles
  int   hold_cnt     = 0;
  bit   squeeze      = 1'b0;   // ask the receiver for one long hold-off
  bit   calm         = 1'b0;

  pyramid_rank_select_2x2_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // Wrap size: zero acts as one, oversize saturates
  function automatic int unsigned span(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned frame_len();
    return span(cfg_in_w, MAX_W) * span(cfg_in_h, MAX_H);
  endfunction

  // Sort the window ascending and take the configured rank, clamped to 1..4
  function automatic pixel_t pick_rank(pixel_t a, pixel_t b, pixel_t c, pixel_t d);
    pixel_t            s [4];
    pixel_t            t;
    logic [RANK_W-1:0] k;
    s[0] = a; s[1] = b; s[2] = c; s[3] = d;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j]; s[j] = s[j+1]; s[j+1] = t;
        end
    k = cfg_rank;
    if (k == RANK_ZERO) k = RANK_MIN;
    else if (k > RANK_MAX) k = RANK_MAX;
    return s[k - 1];
  endfunction

  // Advance one raster pixel; return 1 when it closes a window inside the output grid
  function automatic bit rank_window_step(input pixel_t px, output window_out_t res);
    int unsigned xs, ys, c, r;
    bit          hit;
    xs  = (cfg_in_w > MAX_W) ? MAX_W / 2 : cfg_in_w / 2;
    ys  = (cfg_in_h > MAX_H) ? MAX_H / 2 : cfg_in_h / 2;
    if (cfg_out_w < xs) xs = cfg_out_w;
    if (cfg_out_h < ys) ys = cfg_out_h;
    c   = col_pos;
    r   = row_pos;
    hit = 1'b0;
    res = '0;
    if (c / 2 < xs && r / 2 < ys && c < MAX_W) begin
      if (r[0] == 1'b0) begin
        line_buf[c] = px;
      end else if (c[0] == 1'b0) begin
        left_px = px;
      end else begin
        res.pix       = pick_rank(line_buf[c-1], line_buf[c], left_px, px);
        res.row_end   = (c / 2 == xs - 1);
        res.frame_end = res.row_end && (r / 2 == ys - 1);
        hit = 1'b1;
      end
    end
    if (c + 1 >= span(cfg_in_w, MAX_W)) begin
      col_pos = 0;
      row_pos = (r + 1 >= span(cfg_in_h, MAX_H)) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return hit;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  function automatic pixel_t rand_pixel();
    // lean on the extremes now and then so windows carry ties
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [LIM_W-1:0] rand_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2:    return LIM_W'($urandom_range(1, 4));
      3:       return 11'd2047;
      4:       return 11'd1024;
      default: return LIM_W'($urandom_range(5, 2047));
    endcase
  endfunction

  function automatic stim_row_t reg_row(logic [IDX_W-1:0] idx, logic [15:0] val);
    stim_row_t r;
    r.kind = ROW_REG; r.idx = idx; r.val = val; r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t pix_row(pixel_t p);
    stim_row_t r;
    r.kind = ROW_PIX; r.idx = '0; r.val = 16'(p); r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t want_row(pixel_t p, pixel_t v, logic re, logic fe);
    stim_row_t r;
    r.kind = ROW_PIX; r.idx = '0; r.val = 16'(p); r.typed = 1'b1;
    r.want = '{pix: v, row_end: re, frame_end: fe};
    return r;
  endfunction

  function automatic stim_row_t fill_row(int n);
    stim_row_t r;
    r.kind = ROW_FILL; r.idx = '0; r.val = 16'(n); r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  // Drop valid and wait until every owed window is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // Write one register with the block idle, then mirror it into the predictor
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
    case (idx)
      REG_IN_WIDTH:   cfg_in_w  = val;
      REG_IN_HEIGHT:  cfg_in_h  = val;
      REG_OUT_WIDTH:  cfg_out_w = val[LIM_W-1:0];
      REG_OUT_HEIGHT: cfg_out_h = val[LIM_W-1:0];
      REG_RANK:       cfg_rank  = val[RANK_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one pixel, hold it until transfer, then record what the window should yield
  task automatic send_pixel(input pixel_t px, input bit typed, input window_out_t want);
    window_out_t got;
    int          gap;
    if (!calm && hold_cnt == 0 && gap_rate != 0 && $urandom_range(0, gap_rate) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    // typed rows override the predictor, but the predictor still advances
    if (rank_window_step(px, got) || typed) ranked_q.push_back(typed ? want : got);
  endtask

  // ------------------------------------------------------------------
  // Output side: stall in bursts, hold off once on request, check transfers
  // ------------------------------------------------------------------
  initial begin : receiver
    window_out_t w;
    int          stall_left;
    int          stall_rate;   // 0 = always ready, larger = rarer bursts
    int          tick;
    stall_left = 0;
    stall_rate = 1;
    tick       = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (ranked_q.size() == 0) begin
          errors++;
          $display("%0t: window out with none owed: pixel_out %0d row_end %0b frame_end %0b",
                   $time, pixel_out, row_end, frame_end);
        end else begin
          w = ranked_q.pop_front();
          windows_seen++;
          if (pixel_out !== w.pix) begin
            errors++;
            $display("%0t: pixel_out expected %0d, got %0d", $time, w.pix, pixel_out);
          end
          if (row_end !== w.row_end) begin
            errors++;
            $display("%0t: row_end expected %0b, got %0b", $time, w.row_end, row_end);
          end
          if (frame_end !== w.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %0b, got %0b", $time, w.frame_end, frame_end);
          end
        end
      end
      tick++;
      if (tick % 128 == 0) stall_rate = $urandom_range(0, 3);
      if (squeeze) begin
        squeeze  = 1'b0;
        hold_cnt = HOLD_OFF_CYCLES;
      end
      // long hold-off first, then any burst in progress, then maybe start one
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && stall_rate != 0 && $urandom_range(0, 2 * stall_rate) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Timeout
  // ------------------------------------------------------------------
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run stalled, cycle limit %0d reached", $time, CYCLE_LIMIT);
    $display("** pyramid_rank_select_2x2_unit: FAILED **");
    $finish;
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   row;
    int unsigned len;
    int          nframes;
    int          rand_pixels;
    int          sel;
    bit          tweak;

    rand_pixels = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // 2x2 frames: rank zero acts as minimum, rank change mid-frame, rank 7 acts as maximum.
    // Window values sort to 0, 7, 200, 255.
    dir_rows.push_back(reg_row(REG_IN_WIDTH, 2));
    dir_rows.push_back(reg_row(REG_IN_HEIGHT, 2));
    dir_rows.push_back(reg_row(REG_RANK, RANK_ZERO));
    dir_rows.push_back(pix_row(7));
    dir_rows.push_back(pix_row(200));
    dir_rows.push_back(pix_row(0));
    dir_rows.push_back(want_row(255, 0, 1'b1, 1'b1));
    dir_rows.push_back(pix_row(255));
    dir_rows.push_back(pix_row(0));
    dir_rows.push_back(reg_row(REG_RANK, RANK_HI));
    dir_rows.push_back(pix_row(200));
    dir_rows.push_back(want_row(7, 200, 1'b1, 1'b1));
    dir_rows.push_back(reg_row(REG_RANK, RANK_ALL_SET));
    dir_rows.push_back(pix_row(0));
    dir_rows.push_back(pix_row(255));
    dir_rows.push_back(pix_row(7));
    dir_rows.push_back(want_row(200, 255, 1'b1, 1'b1));
    // zero width wraps every pixel; zero height with an odd width; neither gives output
    dir_rows.push_back(reg_row(REG_IN_WIDTH, 0));
    dir_rows.push_back(pix_row(255));
    dir_rows.push_back(pix_row(0));
    dir_rows.push_back(reg_row(REG_IN_WIDTH, 3));
    dir_rows.push_back(reg_row(REG_IN_HEIGHT, 0));
    dir_rows.push_back(pix_row(1));
    dir_rows.push_back(pix_row(254));
    dir_rows.push_back(pix_row(128));
    // oversized height saturates; one output row of one window, then cut the
    // height so the row position past it wraps the frame within two pixels
    dir_rows.push_back(reg_row(REG_IN_WIDTH, 2));
    dir_rows.push_back(reg_row(REG_IN_HEIGHT, 4095));
    dir_rows.push_back(reg_row(REG_OUT_WIDTH, 2047));
    dir_rows.push_back(reg_row(REG_OUT_HEIGHT, 1));
    dir_rows.push_back(reg_row(REG_RANK, RANK_LO));
    dir_rows.push_back(pix_row(9));
    dir_rows.push_back(pix_row(3));
    dir_rows.push_back(pix_row(250));
    dir_rows.push_back(want_row(4, 4, 1'b1, 1'b1));
    dir_rows.push_back(reg_row(REG_IN_HEIGHT, 2));
    dir_rows.push_back(fill_row(2));
    // oversized width: top pair at the row start, then cut the width so the
    // column position past it wraps to the bottom row on the next pixel
    dir_rows.push_back(reg_row(REG_IN_WIDTH, 4095));
    dir_rows.push_back(reg_row(REG_OUT_WIDTH, 1));
    dir_rows.push_back(reg_row(REG_RANK, RANK_HI));
    dir_rows.push_back(pix_row(100));
    dir_rows.push_back(pix_row(50));
    dir_rows.push_back(reg_row(REG_IN_WIDTH, 2));
    dir_rows.push_back(fill_row(1));
    dir_rows.push_back(pix_row(60));
    dir_rows.push_back(want_row(70, 70, 1'b1, 1'b1));

    gap_rate = 4;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_REG:  write_reg(row.idx, row.val[CFG_W-1:0]);
        ROW_PIX:  send_pixel(row.val[PIX_W-1:0], row.typed, row.want);
        ROW_FILL: repeat (row.val) send_pixel(rand_pixel(), 1'b0, '0);
        default: ;
      endcase
    end

    // Random part: whole frames per setting so each setup starts at the frame origin
    while (rand_pixels < RAND_ITEMS) begin
      if (rand_pixels >= CALM_AFTER) calm = 1'b1;
      if (phases == 0) begin
        // dense first setup: fill the block while the receiver holds off
        write_reg(REG_IN_WIDTH, 16);
        write_reg(REG_IN_HEIGHT, 8);
        write_reg(REG_OUT_WIDTH, CFG_W'(RST_OUT_WIDTH));
        write_reg(REG_OUT_HEIGHT, CFG_W'(RST_OUT_HEIGHT));
        write_reg(REG_RANK, CFG_W'($urandom_range(0, 7)));
        squeeze = 1'b1;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          write_reg(REG_IN_WIDTH, CFG_W'($urandom_range(0, 1)));
          write_reg(REG_IN_HEIGHT, CFG_W'($urandom_range(0, 6)));
        end else if (sel < 8) begin
          write_reg(REG_IN_WIDTH, CFG_W'($urandom_range(2, 16)));
          write_reg(REG_IN_HEIGHT,
                    CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                       : $urandom_range(2, 10)));
        end else begin
          write_reg(REG_IN_WIDTH, CFG_W'($urandom_range(17, 48)));
          write_reg(REG_IN_HEIGHT, CFG_W'($urandom_range(2, 4)));
        end
        write_reg(REG_OUT_WIDTH, CFG_W'(rand_limit()));
        write_reg(REG_OUT_HEIGHT, CFG_W'(rand_limit()));
        write_reg(REG_RANK, CFG_W'($urandom_range(0, 7)));
      end
      gap_rate = $urandom_range(0, 6);
      nframes  = $urandom_range(1, 3);
      tweak    = ($urandom_range(0, 3) == 0);
      len      = frame_len();
      for (int f = 0; f < nframes; f++) begin
        for (int unsigned k = 0; k < len; k++) begin
          // mid-frame: swap rank, only shrink the column limit so no read hits
          // a line-buffer entry this frame never wrote
          if (tweak && f == 0 && len >= 4 && k == len / 2) begin
            write_reg(REG_RANK, CFG_W'($urandom_range(0, 7)));
            write_reg(REG_OUT_WIDTH, CFG_W'($urandom_range(0, cfg_out_w)));
          end
          send_pixel(rand_pixel(), 1'b0, '0);
          rand_pixels++;
        end
      end
      phases++;
    end

    // Drain, then give the block time to show any stray output
    settle();
    repeat (PIPE_DEPTH * 8) @(posedge clk);

    $display("Covered %0d pixel transfers: directed rows plus %0d random frame setups,",
             pixels_sent, phases);
    $display("%0d register writes, %0d windows checked, %0d mismatches.",
             reg_writes, windows_seen, errors);
    if (errors == 0) begin
      $display("** pyramid_rank_select_2x2_unit: PASSED **");
    end else begin
      $display("** pyramid_rank_select_2x2_unit: FAILED **");
    end
    $finish;
  end

endmodule
